@@ hw/rtl/mi3_pkg.sv @@
// Shared types and constants for the 3x3 adjugate matrix inverse.
// No dependencies; used by every module of the block.
`default_nettype none

package mi3_pkg;

    localparam int ENTRY_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FIELD_WIDTH = 32;
    localparam int NUM_ENT     = 9;

    // one request: the nine matrix entries, row-major
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] a00;
        logic [FIELD_WIDTH-1:0] a01;
        logic [FIELD_WIDTH-1:0] a02;
        logic [FIELD_WIDTH-1:0] a10;
        logic [FIELD_WIDTH-1:0] a11;
        logic [FIELD_WIDTH-1:0] a12;
        logic [FIELD_WIDTH-1:0] a20;
        logic [FIELD_WIDTH-1:0] a21;
        logic [FIELD_WIDTH-1:0] a22;
    } mat_in_t;

    // one result: inverse entries, row-major, plus singular flag
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] b00;
        logic [FIELD_WIDTH-1:0] b01;
        logic [FIELD_WIDTH-1:0] b02;
        logic [FIELD_WIDTH-1:0] b10;
        logic [FIELD_WIDTH-1:0] b11;
        logic [FIELD_WIDTH-1:0] b12;
        logic [FIELD_WIDTH-1:0] b20;
        logic [FIELD_WIDTH-1:0] b21;
        logic [FIELD_WIDTH-1:0] b22;
        logic                   singular;
    } mat_out_t;

    // pipeline control handed to every stage
    typedef struct packed {
        logic valid;
        logic en;
    } pipe_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mi3_cofactor.sv @@
// Cofactor stages: eighteen 2x2 products, then nine differences.
// Depends on mi3_pkg.
`default_nettype none

module mi3_cofactor #(
    parameter int EW = mi3_pkg::ENTRY_WIDTH
) (
    input  wire                                           clk,
    input  wire                                           rst_n,
    input  mi3_pkg::pipe_ctl_t                            ctl,
    input  wire  [mi3_pkg::NUM_ENT-1:0][mi3_pkg::FIELD_WIDTH-1:0] ent,
    output logic                                          valid,
    output logic [2:0][EW-1:0]                            row0,
    output logic [mi3_pkg::NUM_ENT-1:0][2*EW-1:0]         cof
);
    localparam int CW = 2 * EW;
    // operand pairs: cof k = prod 2k - prod 2k+1
    localparam int MUL_L [18] = '{4, 7, 2, 1, 1, 4, 5, 8, 0, 2, 2, 0, 3, 6, 1, 0, 0, 1};
    localparam int MUL_R [18] = '{8, 5, 7, 8, 5, 2, 6, 3, 8, 6, 3, 5, 7, 4, 6, 7, 4, 3};

    logic signed [EW-1:0] ea [mi3_pkg::NUM_ENT];
    logic signed [CW-1:0] prod_next [18];
    logic signed [CW-1:0] prod_reg  [18];
    logic [2:0][EW-1:0]   row0_reg;
    logic                 v1_reg;
    logic [mi3_pkg::NUM_ENT-1:0][CW-1:0] cof_next;
    logic [mi3_pkg::NUM_ENT-1:0][CW-1:0] cof_reg;
    logic [2:0][EW-1:0]   row0b_reg;
    logic                 v2_reg;

    always_comb
    begin
        for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
        begin
            ea[k] = ent[k][EW-1:0];
        end
        for (int p = 0; p < 18; p++)
        begin
            prod_next[p] = ea[MUL_L[p]] * ea[MUL_R[p]];
        end
        for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
        begin
            cof_next[k] = prod_reg[2*k] - prod_reg[2*k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int p = 0; p < 18; p++)
            begin
                prod_reg[p] <= prod_next[p];
            end
            for (int k = 0; k < 3; k++)
            begin
                row0_reg[k] <= ent[k][EW-1:0];
            end
            cof_reg   <= cof_next;
            row0b_reg <= row0_reg;
        end
    end

    assign valid = v2_reg;
    assign row0  = row0b_reg;
    assign cof   = cof_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mi3_det.sv @@
// Determinant stages: split products, term assembly, sum, then magnitudes.
// Depends on mi3_pkg.
`default_nettype none

module mi3_det #(
    parameter int EW = mi3_pkg::ENTRY_WIDTH,
    parameter int FB = mi3_pkg::FRAC_BITS
) (
    input  wire                                              clk,
    input  wire                                              rst_n,
    input  mi3_pkg::pipe_ctl_t                               ctl,
    input  wire  [2:0][EW-1:0]                               row0,
    input  wire  [mi3_pkg::NUM_ENT-1:0][2*EW-1:0]            cof,
    output logic                                             valid,
    output logic                                             sing,
    output logic [3*EW+1:0]                                  dmag,
    output logic [mi3_pkg::NUM_ENT-1:0]                      neg,
    output logic [mi3_pkg::NUM_ENT-1:0][2*EW+2*FB-1:0]       num
);
    localparam int CW  = 2 * EW;
    localparam int DTW = 3 * EW + 2;
    localparam int NW  = CW + 2 * FB;

    // stage 3: a0k times high and low halves of cofactor 3k
    logic signed [CW-1:0] ph_next [3];
    logic signed [CW:0]   pl_next [3];
    logic signed [CW-1:0] ph_reg  [3];
    logic signed [CW:0]   pl_reg  [3];
    logic [mi3_pkg::NUM_ENT-1:0][CW-1:0] cof3_reg, cof4_reg, cof5_reg;
    logic v3_reg, v4_reg, v5_reg, v6_reg;
    // stage 4 / 5
    logic signed [DTW-1:0] term_next [3];
    logic signed [DTW-1:0] term_reg  [3];
    logic signed [DTW-1:0] det_next, det_reg;
    // stage 6
    logic                  dneg;
    logic [DTW-1:0]        dmag_next, dmag_reg;
    logic                  sing_reg;
    logic [mi3_pkg::NUM_ENT-1:0]         neg_next, neg_reg;
    logic [mi3_pkg::NUM_ENT-1:0][NW-1:0] num_next, num_reg;
    logic [CW-1:0]         cmag;
    logic [NW-1:0]         cwide;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ph_next[k] = $signed(row0[k]) * $signed(cof[3*k][CW-1:EW]);
            pl_next[k] = $signed(row0[k]) * $signed({1'b0, cof[3*k][EW-1:0]});
            term_next[k] = ({{(DTW-CW){ph_reg[k][CW-1]}}, ph_reg[k]} <<< EW)
                         + {{(DTW-CW-1){pl_reg[k][CW]}}, pl_reg[k]};
        end
        det_next  = term_reg[0] + term_reg[1] + term_reg[2];
        dneg      = det_reg[DTW-1];
        dmag_next = dneg ? DTW'(-det_reg) : DTW'(det_reg);
        cmag      = '0;
        cwide     = '0;
        for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
        begin
            cmag            = cof5_reg[k][CW-1] ? (~cof5_reg[k] + 1'b1) : cof5_reg[k];
            cwide           = '0;
            cwide[CW-1:0]   = cmag;
            num_next[k]     = cwide << (2 * FB);
            neg_next[k]     = cof5_reg[k][CW-1] ^ dneg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v3_reg <= ctl.valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ph_reg[k]   <= ph_next[k];
                pl_reg[k]   <= pl_next[k];
                term_reg[k] <= term_next[k];
            end
            cof3_reg <= cof;
            cof4_reg <= cof3_reg;
            cof5_reg <= cof4_reg;
            det_reg  <= det_next;
            dmag_reg <= dmag_next;
            sing_reg <= (det_reg == '0);
            neg_reg  <= neg_next;
            num_reg  <= num_next;
        end
    end

    assign valid = v6_reg;
    assign sing  = sing_reg;
    assign dmag  = dmag_reg;
    assign neg   = neg_reg;
    assign num   = num_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mi3_div_stage.sv @@
// One restoring-division step: settles quotient bit BIT in all nine lanes.
// Depends on mi3_pkg.
`default_nettype none

module mi3_div_stage #(
    parameter int RW  = 8,
    parameter int DTW = 8,
    parameter int QW  = 8,
    parameter int BIT = 0
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  mi3_pkg::pipe_ctl_t                        ctl,
    input  wire  [DTW-1:0]                            den_in,
    input  wire  [mi3_pkg::NUM_ENT-1:0][RW-1:0]       rem_in,
    input  wire  [mi3_pkg::NUM_ENT-1:0][QW-1:0]       q_in,
    input  wire  [mi3_pkg::NUM_ENT-1:0]               side_in,
    input  wire  [mi3_pkg::NUM_ENT-1:0]               ovf_in,
    input  wire                                       sing_in,
    output logic                                      valid,
    output logic [DTW-1:0]                            den_out,
    output logic [mi3_pkg::NUM_ENT-1:0][RW-1:0]       rem_out,
    output logic [mi3_pkg::NUM_ENT-1:0][QW-1:0]       q_out,
    output logic [mi3_pkg::NUM_ENT-1:0]               side_out,
    output logic [mi3_pkg::NUM_ENT-1:0]               ovf_out,
    output logic                                      sing_out
);
    logic [RW-1:0] shd;
    logic [mi3_pkg::NUM_ENT-1:0][RW-1:0] rem_next, rem_reg;
    logic [mi3_pkg::NUM_ENT-1:0][QW-1:0] q_next, q_reg;
    logic [DTW-1:0] den_reg;
    logic [mi3_pkg::NUM_ENT-1:0] side_reg, ovf_reg;
    logic sing_reg, v_reg;

    always_comb
    begin
        shd            = '0;
        shd[DTW-1:0]   = den_in;
        shd            = shd << BIT;
        for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
        begin
            rem_next[k] = rem_in[k];
            q_next[k]   = q_in[k];
            if (rem_in[k] >= shd)
            begin
                rem_next[k]    = rem_in[k] - shd;
                q_next[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            den_reg  <= den_in;
            side_reg <= side_in;
            ovf_reg  <= ovf_in;
            sing_reg <= sing_in;
        end
    end

    assign valid    = v_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;
    assign ovf_out  = ovf_reg;
    assign sing_out = sing_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mi3_divider.sv @@
// Nine-lane pipelined divider: range check stage, then one stage per quotient bit.
// Depends on mi3_pkg and mi3_div_stage.
`default_nettype none

module mi3_divider #(
    parameter int EW = mi3_pkg::ENTRY_WIDTH,
    parameter int FB = mi3_pkg::FRAC_BITS
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  mi3_pkg::pipe_ctl_t                           ctl,
    input  wire  [3*EW+1:0]                              dmag,
    input  wire                                          sing,
    input  wire  [mi3_pkg::NUM_ENT-1:0]                  neg,
    input  wire  [mi3_pkg::NUM_ENT-1:0][2*EW+2*FB-1:0]   num,
    output logic                                         valid,
    output logic [mi3_pkg::NUM_ENT-1:0][EW:0]            quo,
    output logic [mi3_pkg::NUM_ENT-1:0]                  quo_neg,
    output logic [mi3_pkg::NUM_ENT-1:0]                  quo_ovf,
    output logic                                         quo_sing
);
    localparam int DTW = 3 * EW + 2;
    localparam int NW  = 2 * EW + 2 * FB;
    localparam int QW  = EW + 1;
    localparam int RW  = ((NW > DTW + QW) ? NW : DTW + QW) + 1;

    logic [RW-1:0] dlim;
    logic [mi3_pkg::NUM_ENT-1:0][RW-1:0] rem0_next, rem0_reg;
    logic [mi3_pkg::NUM_ENT-1:0] ovf0_next, ovf0_reg, neg0_reg;
    logic [DTW-1:0] den0_reg;
    logic sing0_reg, v0_reg;

    // stage chain wiring, index s feeds step s
    logic                                 v_c    [QW+1];
    logic [DTW-1:0]                       den_c  [QW+1];
    logic [mi3_pkg::NUM_ENT-1:0][RW-1:0]  rem_c  [QW+1];
    logic [mi3_pkg::NUM_ENT-1:0][QW-1:0]  q_c    [QW+1];
    logic [mi3_pkg::NUM_ENT-1:0]          side_c [QW+1];
    logic [mi3_pkg::NUM_ENT-1:0]          ovf_c  [QW+1];
    logic                                 sing_c [QW+1];

    // quotient fits QW bits only when num < den << QW
    always_comb
    begin
        dlim          = '0;
        dlim[DTW-1:0] = dmag;
        dlim          = dlim << QW;
        for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
        begin
            rem0_next[k]         = '0;
            rem0_next[k][NW-1:0] = num[k];
            ovf0_next[k]         = (rem0_next[k] >= dlim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v0_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem0_reg  <= rem0_next;
            ovf0_reg  <= ovf0_next;
            neg0_reg  <= neg;
            den0_reg  <= dmag;
            sing0_reg <= sing;
        end
    end

    assign v_c[0]    = v0_reg;
    assign den_c[0]  = den0_reg;
    assign rem_c[0]  = rem0_reg;
    assign q_c[0]    = '0;
    assign side_c[0] = neg0_reg;
    assign ovf_c[0]  = ovf0_reg;
    assign sing_c[0] = sing0_reg;

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        mi3_div_stage #(
            .RW  (RW),
            .DTW (DTW),
            .QW  (QW),
            .BIT (QW - 1 - s)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      ('{valid: v_c[s], en: ctl.en}),
            .den_in   (den_c[s]),
            .rem_in   (rem_c[s]),
            .q_in     (q_c[s]),
            .side_in  (side_c[s]),
            .ovf_in   (ovf_c[s]),
            .sing_in  (sing_c[s]),
            .valid    (v_c[s+1]),
            .den_out  (den_c[s+1]),
            .rem_out  (rem_c[s+1]),
            .q_out    (q_c[s+1]),
            .side_out (side_c[s+1]),
            .ovf_out  (ovf_c[s+1]),
            .sing_out (sing_c[s+1])
        );
    end

    assign valid    = v_c[QW];
    assign quo      = q_c[QW];
    assign quo_neg  = side_c[QW];
    assign quo_ovf  = ovf_c[QW];
    assign quo_sing = sing_c[QW];

endmodule

`default_nettype wire

@@ hw/rtl/matrix3_inverse_adjugate.sv @@
// Top level of the 3x3 fixed-point matrix inverse (adjugate over determinant).
// Depends on mi3_pkg, mi3_cofactor, mi3_det and mi3_divider.
`default_nettype none

// Each request carries one 3x3 matrix of signed fixed-point entries (low EW
// bits of each field, FB fraction bits). The result is the transposed cofactor
// matrix divided by the exact determinant, truncated toward zero and saturated
// to the signed EW-bit range, sign-extended into 32-bit fields. A zero
// determinant gives all-zero entries with singular set. The block is a single
// pipeline of EW+9 stages (41 at the default width): two for the cofactor
// products, four for the determinant, one range check, one restoring-divide
// step per quotient bit (EW+1, nine lanes side by side) and the output register.
// A request is taken every cycle while no valid result sits stalled at the
// output. When one does, the whole pipeline holds, so a stall costs throughput
// only while it lasts and nothing inside is dropped or duplicated.

module matrix3_inverse_adjugate #(
    parameter int EW = mi3_pkg::ENTRY_WIDTH,
    parameter int FB = mi3_pkg::FRAC_BITS
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                a_valid,
    output logic               a_stall,
    input  mi3_pkg::mat_in_t   a,
    output logic               b_valid,
    input  wire                b_stall,
    output mi3_pkg::mat_out_t  b
);
    localparam int CW  = 2 * EW;
    localparam int DTW = 3 * EW + 2;
    localparam int NW  = CW + 2 * FB;
    localparam int QW  = EW + 1;

    logic en;
    logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::FIELD_WIDTH-1:0] ent;

    logic                                 cof_valid;
    logic [2:0][EW-1:0]                   row0;
    logic [mi3_pkg::NUM_ENT-1:0][CW-1:0]  cof;

    logic                                 det_valid;
    logic                                 det_sing;
    logic [DTW-1:0]                       dmag;
    logic [mi3_pkg::NUM_ENT-1:0]          dneg;
    logic [mi3_pkg::NUM_ENT-1:0][NW-1:0]  num;

    logic                                 div_valid;
    logic [mi3_pkg::NUM_ENT-1:0][QW-1:0]  quo;
    logic [mi3_pkg::NUM_ENT-1:0]          quo_neg;
    logic [mi3_pkg::NUM_ENT-1:0]          quo_ovf;
    logic                                 quo_sing;

    logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::FIELD_WIDTH-1:0] res;
    logic [QW-1:0]        lim, mq, rq;
    logic signed [EW-1:0] rs;
    mi3_pkg::mat_out_t    b_next, b_reg;
    logic                 b_valid_reg;

    // whole pipeline advances unless a finished result sits stalled
    assign en      = !(b_valid_reg && b_stall);
    assign a_stall = !en;

    assign ent = {a.a22, a.a21, a.a20, a.a12, a.a11, a.a10, a.a02, a.a01, a.a00};

    mi3_cofactor #(
        .EW (EW)
    ) u_cof (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{valid: a_valid, en: en}),
        .ent   (ent),
        .valid (cof_valid),
        .row0  (row0),
        .cof   (cof)
    );

    mi3_det #(
        .EW (EW),
        .FB (FB)
    ) u_det (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{valid: cof_valid, en: en}),
        .row0  (row0),
        .cof   (cof),
        .valid (det_valid),
        .sing  (det_sing),
        .dmag  (dmag),
        .neg   (dneg),
        .num   (num)
    );

    mi3_divider #(
        .EW (EW),
        .FB (FB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{valid: det_valid, en: en}),
        .dmag     (dmag),
        .sing     (det_sing),
        .neg      (dneg),
        .num      (num),
        .valid    (div_valid),
        .quo      (quo),
        .quo_neg  (quo_neg),
        .quo_ovf  (quo_ovf),
        .quo_sing (quo_sing)
    );

    // saturate: limit is 2^(EW-1) for negative results, 2^(EW-1)-1 otherwise
    always_comb
    begin
        lim = '0;
        mq  = '0;
        rq  = '0;
        rs  = '0;
        for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
        begin
            lim = '0;
            if (quo_neg[k])
            begin
                lim[EW-1] = 1'b1;
            end
            else
            begin
                lim[EW-2:0] = '1;
            end
            mq     = (quo_ovf[k] || (quo[k] > lim)) ? lim : quo[k];
            rq     = quo_neg[k] ? (~mq + 1'b1) : mq;
            rs     = rq[EW-1:0];
            res[k] = quo_sing ? '0 : mi3_pkg::FIELD_WIDTH'(rs);
        end
        b_next.b00      = res[0];
        b_next.b01      = res[1];
        b_next.b02      = res[2];
        b_next.b10      = res[3];
        b_next.b11      = res[4];
        b_next.b12      = res[5];
        b_next.b20      = res[6];
        b_next.b21      = res[7];
        b_next.b22      = res[8];
        b_next.singular = quo_sing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg <= b_next;
        end
    end

    assign b_valid = b_valid_reg;
    assign b       = b_reg;

    // singular result carries only zero entries
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_reg.singular |->
            b_reg.b00 == '0 && b_reg.b01 == '0 && b_reg.b02 == '0 &&
            b_reg.b10 == '0 && b_reg.b11 == '0 && b_reg.b12 == '0 &&
            b_reg.b20 == '0 && b_reg.b21 == '0 && b_reg.b22 == '0)
        else $error("singular result with nonzero entries");

    // entries are sign extensions of an EW-bit value
    a_b00_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (&b_reg.b00[mi3_pkg::FIELD_WIDTH-1:EW-1]) ||
                        !(|b_reg.b00[mi3_pkg::FIELD_WIDTH-1:EW-1]))
        else $error("b00 outside entry range");

    a_b22_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (&b_reg.b22[mi3_pkg::FIELD_WIDTH-1:EW-1]) ||
                        !(|b_reg.b22[mi3_pkg::FIELD_WIDTH-1:EW-1]))
        else $error("b22 outside entry range");

    // a held pipeline keeps the divider output in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(div_valid) && $stable(quo))
        else $error("divider output moved while held");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for matrix3_inverse_adjugate: 3x3 fixed-point inverse via adjugate.
// Depends on mi3_pkg and the RTL of the block; directed table then random matrices.
`timescale 1ns / 1ps

module testbench;

    localparam int PERIOD   = 12;
    localparam int LATENCY  = mi3_pkg::ENTRY_WIDTH + 9;
    localparam int N_RANDOM = 1000;

    logic               clk;
    logic               rst_n;
    logic               a_valid;
    logic               a_stall;
    mi3_pkg::mat_in_t   a;
    logic               b_valid;
    logic               b_stall;
    mi3_pkg::mat_out_t  b;

    matrix3_inverse_adjugate dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_valid (a_valid),
        .a_stall (a_stall),
        .a       (a),
        .b_valid (b_valid),
        .b_stall (b_stall),
        .b       (b)
    );

    // expected inverses, oldest first
    mi3_pkg::mat_out_t inverse_q[$];
    int                errors;
    int                send_idle_pct;
    int                recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    // Run limit: 1000+ requests at 59% stall worst case finish far under this.
    initial
    begin
        #(PERIOD * 400000);
        $display("FAILURE");
        $finish;
    end

    // Low ENTRY_WIDTH bits as a signed value.
    function automatic logic signed [63:0] entry_value(
        input logic [mi3_pkg::FIELD_WIDTH-1:0] f);
        logic signed [mi3_pkg::ENTRY_WIDTH-1:0] e;
        e = f[mi3_pkg::ENTRY_WIDTH-1:0];
        return 64'(e);
    endfunction

    // Cofactor over the determinant, truncated toward zero, saturated.
    function automatic logic [mi3_pkg::FIELD_WIDTH-1:0] scaled_entry(
        input logic signed [127:0] cof,
        input logic signed [127:0] det);
        logic [127:0]            num;
        logic [127:0]            den;
        logic [127:0]            quo;
        logic                    neg;
        logic [127:0]            lim;
        logic signed [63:0]      res;
        neg = (cof < 0) != (det < 0);
        num = ((cof < 0) ? -cof : cof) << (2 * mi3_pkg::FRAC_BITS);
        den = (det < 0) ? -det : det;
        quo = num / den;
        lim = (128'd1 << (mi3_pkg::ENTRY_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
        if (quo > lim)
            quo = lim;
        res = neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
        return res[mi3_pkg::FIELD_WIDTH-1:0];
    endfunction

    // Full inverse of one request.
    function automatic mi3_pkg::mat_out_t invert_matrix(input mi3_pkg::mat_in_t m);
        logic signed [127:0] e[9];
        logic signed [127:0] c[9];
        logic signed [127:0] det;
        mi3_pkg::mat_out_t   r;
        e[0] = entry_value(m.a00); e[1] = entry_value(m.a01); e[2] = entry_value(m.a02);
        e[3] = entry_value(m.a10); e[4] = entry_value(m.a11); e[5] = entry_value(m.a12);
        e[6] = entry_value(m.a20); e[7] = entry_value(m.a21); e[8] = entry_value(m.a22);
        // adjugate, row-major (transposed cofactors)
        c[0] = e[4] * e[8] - e[7] * e[5];
        c[1] = e[2] * e[7] - e[1] * e[8];
        c[2] = e[1] * e[5] - e[4] * e[2];
        c[3] = e[5] * e[6] - e[8] * e[3];
        c[4] = e[0] * e[8] - e[2] * e[6];
        c[5] = e[2] * e[3] - e[0] * e[5];
        c[6] = e[3] * e[7] - e[6] * e[4];
        c[7] = e[1] * e[6] - e[0] * e[7];
        c[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * c[0] + e[1] * c[3] + e[2] * c[6];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        r.b00 = scaled_entry(c[0], det); r.b01 = scaled_entry(c[1], det);
        r.b02 = scaled_entry(c[2], det); r.b10 = scaled_entry(c[3], det);
        r.b11 = scaled_entry(c[4], det); r.b12 = scaled_entry(c[5], det);
        r.b20 = scaled_entry(c[6], det); r.b21 = scaled_entry(c[7], det);
        r.b22 = scaled_entry(c[8], det);
        return r;
    endfunction

    function automatic mi3_pkg::mat_in_t pack_matrix(input logic [31:0] v[9]);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    endfunction

    // Random entry: mostly modest Q16.16 values, sometimes full-range bits.
    function automatic logic [31:0] random_entry();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return '0;
            3:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            4:       return 32'($signed($urandom_range(0, 8)) - 4) <<< mi3_pkg::FRAC_BITS;
            default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        endcase
    endfunction

    // Directed table: a request and, where obvious, its typed-in result.
    typedef struct {
        mi3_pkg::mat_in_t  req;
        logic              typed;
        mi3_pkg::mat_out_t res;
    } directed_row_t;

    directed_row_t directed[$];

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    task automatic add_row(input logic [31:0] v[9], input logic typed,
                           input mi3_pkg::mat_out_t res);
        directed_row_t row;
        row.req   = pack_matrix(v);
        row.typed = typed;
        row.res   = res;
        directed.push_back(row);
    endtask

    task automatic build_directed();
        mi3_pkg::mat_out_t ident;
        mi3_pkg::mat_out_t sing;
        ident = '0;
        ident.b00 = ONE; ident.b11 = ONE; ident.b22 = ONE;
        sing = '0;
        sing.singular = 1'b1;
        // identity, all-zero (singular), rank-one (singular), zero third row (singular)
        add_row('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1, ident);
        add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, sing);
        add_row('{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1, sing);
        add_row('{MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, 0, 0}, 1'b1, sing);
        // tiny diagonal: inverse saturates high; with a negative tiny entry, its inverse saturates low
        add_row('{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0, '0);
        add_row('{32'hffff_ffff, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0, '0);
        // extremes of the range
        add_row('{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV}, 1'b0, '0);
        add_row('{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV}, 1'b0, '0);
        add_row('{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV}, 1'b0, '0);
        add_row('{MAXV, MINV, 1, MINV, 32'hffff_ffff, MAXV, 1, MAXV, MINV}, 1'b0, '0);
        add_row('{32'hffff_ffff, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 0, 32'hffff_ffff}, 1'b0, '0);
        // truncation toward zero on both signs
        add_row('{3 * ONE, 0, 0, 0, 32'hfffd_0000, 0, 0, 0, 7 * ONE}, 1'b0, '0);
        add_row('{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE}, 1'b0, '0);
        add_row('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}, 1'b0, '0);
    endtask

    // Sender: one request, held until accepted; valid is left for the caller.
    task automatic send_request(input mi3_pkg::mat_in_t req, input mi3_pkg::mat_out_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            a_valid <= 1'b0;
            @(posedge clk);
        end
        a_valid <= 1'b1;
        a       <= req;
        inverse_q.push_back(res);
        do
            @(posedge clk);
        while (a_stall);
    endtask

    // Receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_stall <= 1'b0;
        else
            b_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Result check against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && b_valid && !b_stall)
        begin
            if (inverse_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, b);
                errors++;
            end
            else
            begin
                mi3_pkg::mat_out_t exp_r;
                exp_r = inverse_q.pop_front();
                if (b !== exp_r)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, b);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        mi3_pkg::mat_in_t req;
        logic [31:0]      v[9];
        int               wait_cycles;
        errors        = 0;
        send_idle_pct = 28;
        recv_idle_pct = 59;
        rst_n   = 1'b0;
        a_valid = 1'b0;
        a       = '0;
        build_directed();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i].req,
                         directed[i].typed ? directed[i].res : invert_matrix(directed[i].req));
        a_valid <= 1'b0;

        // hold off until the pipe drains
        wait_cycles = 0;
        while (inverse_q.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 28;
            end
            else if (n == 2 * N_RANDOM / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            foreach (v[k])
                v[k] = random_entry();
            req = pack_matrix(v);
            send_request(req, invert_matrix(req));
        end
        a_valid <= 1'b0;

        wait_cycles = 0;
        while (inverse_q.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (errors == 0 && inverse_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
